// ----- rtl/vhd_pkg.sv -----
package vhd_pkg;

    // datapath widths and pipeline depths
    localparam int Q_WIDTH      = 64;
    localparam int CORDIC_STEPS = 62;
    localparam int DIV_STEPS    = 6;
    localparam int FRONT_STAGES = 4;
    localparam int VHD_LATENCY  = FRONT_STAGES + CORDIC_STEPS + DIV_STEPS + 1;
    localparam int NORM_TOP     = 60;

    // angle constants, radians in unsigned q62
    localparam logic [Q_WIDTH-1:0] PIQ62         = 64'hC90FDAA22168C235;
    localparam logic [Q_WIDTH-1:0] QUARTER_PIQ62 = 64'h3243F6A8885A308D;
    localparam logic [Q_WIDTH-1:0] DEG_Q62       = PIQ62 / 180;

    // heading constants in degrees
    localparam logic [8:0] DEG_0     = 9'd0;
    localparam logic [8:0] DEG_45    = 9'd45;
    localparam logic [8:0] DEG_90    = 9'd90;
    localparam logic [8:0] DEG_180   = 9'd180;
    localparam logic [8:0] DEG_270   = 9'd270;
    localparam logic [5:0] OCT_MAX   = 6'd44;
    localparam logic [6:0] STEEP_TOP = 7'd89;

    // per-beat side information carried down the pipe
    typedef struct packed {
        logic       special;
        logic [8:0] base;
        logic       steep;
    } vhd_meta_t;

    typedef struct packed {
        vhd_meta_t          meta;
        logic [Q_WIDTH-1:0] x;
        logic [Q_WIDTH-1:0] y;
        logic [Q_WIDTH-1:0] z;
    } vhd_beat_t;

    // power of two in q62, zero outside 0..62
    function automatic logic [Q_WIDTH-1:0] vhd_pow2(input int e);
        logic [Q_WIDTH-1:0] r;
        r = '0;
        if (e >= 0 && e <= NORM_TOP + 2)
        begin
            r = 64'd1 << e;
        end
        return r;
    endfunction

endpackage

// ----- rtl/vhd_front.sv -----
module vhd_front #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [COORD_WIDTH-1:0] x_offset,
    input  logic signed [COORD_WIDTH-1:0] y_offset,
    output logic                          out_valid,
    output vhd_pkg::vhd_beat_t            out_beat
);
    import vhd_pkg::*;

    localparam int TOP_W = $clog2(COORD_WIDTH);

    // stage a: magnitudes and signs
    logic                   a_valid_reg;
    logic [COORD_WIDTH-1:0] ax_reg, ay_reg, ax_next, ay_next;
    logic                   xn_reg, yn_reg;

    // stage b: folded pair and classification
    logic                   b_valid_reg;
    logic [COORD_WIDTH-1:0] s_reg, l_reg, s_next, l_next;
    vhd_meta_t              b_meta_reg, b_meta_next;

    // stage c: top set bit of the large side
    logic                   c_valid_reg;
    logic [COORD_WIDTH-1:0] c_s_reg, c_l_reg;
    logic [TOP_W-1:0]       top_reg, top_next;
    vhd_meta_t              c_meta_reg;

    // stage d: normalized cordic start
    logic                   d_valid_reg;
    vhd_beat_t              d_beat_reg, d_beat_next;

    logic [COORD_WIDTH-1:0] a_side, b_side;
    logic [5:0]             sh;

    // two's complement magnitude, most negative value keeps full size
    always_comb
    begin
        ax_next = x_offset[COORD_WIDTH-1] ? (~x_offset + 1'b1) : x_offset;
        ay_next = y_offset[COORD_WIDTH-1] ? (~y_offset + 1'b1) : y_offset;
    end

    // quadrant fold, axis and diagonal detection, octant swap
    always_comb
    begin
        a_side = (xn_reg == yn_reg) ? ax_reg : ay_reg;
        b_side = (xn_reg == yn_reg) ? ay_reg : ax_reg;
        b_meta_next.special = 1'b0;
        b_meta_next.steep   = a_side > b_side;
        if (!xn_reg && yn_reg)
        begin
            b_meta_next.base = DEG_0;
        end
        else if (xn_reg && yn_reg)
        begin
            b_meta_next.base = DEG_90;
        end
        else if (xn_reg && !yn_reg)
        begin
            b_meta_next.base = DEG_180;
        end
        else
        begin
            b_meta_next.base = DEG_270;
        end
        if (ax_reg == '0 && ay_reg == '0)
        begin
            b_meta_next.special = 1'b1;
            b_meta_next.base    = DEG_0;
        end
        else if (ay_reg == '0)
        begin
            b_meta_next.special = 1'b1;
            b_meta_next.base    = xn_reg ? DEG_180 : DEG_0;
        end
        else if (ax_reg == '0)
        begin
            b_meta_next.special = 1'b1;
            b_meta_next.base    = yn_reg ? DEG_90 : DEG_270;
        end
        else if (a_side == b_side)
        begin
            b_meta_next.special = 1'b1;
            b_meta_next.base    = b_meta_next.base + DEG_45;
        end
        s_next = b_meta_next.steep ? b_side : a_side;
        l_next = b_meta_next.steep ? a_side : b_side;
    end

    // priority encoder for the top set bit
    always_comb
    begin
        top_next = '0;
        for (int k = 0; k < COORD_WIDTH; k++)
        begin
            if (l_reg[k])
            begin
                top_next = TOP_W'(k);
            end
        end
    end

    // shift both sides so the large one has its top bit at bit 60
    always_comb
    begin
        sh                 = 6'(NORM_TOP - int'(top_reg));
        d_beat_next.meta   = c_meta_reg;
        d_beat_next.x      = Q_WIDTH'(c_l_reg) << sh;
        d_beat_next.y      = Q_WIDTH'(c_s_reg) << sh;
        d_beat_next.z      = '0;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= start;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        xn_reg     <= x_offset[COORD_WIDTH-1];
        yn_reg     <= y_offset[COORD_WIDTH-1];
        s_reg      <= s_next;
        l_reg      <= l_next;
        b_meta_reg <= b_meta_next;
        c_s_reg    <= s_reg;
        c_l_reg    <= l_reg;
        top_reg    <= top_next;
        c_meta_reg <= b_meta_reg;
        d_beat_reg <= d_beat_next;
    end

    assign out_valid = d_valid_reg;
    assign out_beat  = d_beat_reg;

endmodule

// ----- rtl/vhd_cordic_stage.sv -----
module vhd_cordic_stage #(
    parameter int STAGE = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  vhd_pkg::vhd_beat_t in_beat,
    output logic               out_valid,
    output vhd_pkg::vhd_beat_t out_beat
);
    import vhd_pkg::*;

    // atan(2^-stage) as the truncated alternating series
    localparam logic [Q_WIDTH-1:0] T0  = vhd_pow2(62 - STAGE * 1) / 1;
    localparam logic [Q_WIDTH-1:0] T1  = vhd_pow2(62 - STAGE * 3) / 3;
    localparam logic [Q_WIDTH-1:0] T2  = vhd_pow2(62 - STAGE * 5) / 5;
    localparam logic [Q_WIDTH-1:0] T3  = vhd_pow2(62 - STAGE * 7) / 7;
    localparam logic [Q_WIDTH-1:0] T4  = vhd_pow2(62 - STAGE * 9) / 9;
    localparam logic [Q_WIDTH-1:0] T5  = vhd_pow2(62 - STAGE * 11) / 11;
    localparam logic [Q_WIDTH-1:0] T6  = vhd_pow2(62 - STAGE * 13) / 13;
    localparam logic [Q_WIDTH-1:0] T7  = vhd_pow2(62 - STAGE * 15) / 15;
    localparam logic [Q_WIDTH-1:0] T8  = vhd_pow2(62 - STAGE * 17) / 17;
    localparam logic [Q_WIDTH-1:0] T9  = vhd_pow2(62 - STAGE * 19) / 19;
    localparam logic [Q_WIDTH-1:0] T10 = vhd_pow2(62 - STAGE * 21) / 21;
    localparam logic [Q_WIDTH-1:0] T11 = vhd_pow2(62 - STAGE * 23) / 23;
    localparam logic [Q_WIDTH-1:0] T12 = vhd_pow2(62 - STAGE * 25) / 25;
    localparam logic [Q_WIDTH-1:0] T13 = vhd_pow2(62 - STAGE * 27) / 27;
    localparam logic [Q_WIDTH-1:0] T14 = vhd_pow2(62 - STAGE * 29) / 29;
    localparam logic [Q_WIDTH-1:0] T15 = vhd_pow2(62 - STAGE * 31) / 31;
    localparam logic [Q_WIDTH-1:0] T16 = vhd_pow2(62 - STAGE * 33) / 33;
    localparam logic [Q_WIDTH-1:0] T17 = vhd_pow2(62 - STAGE * 35) / 35;
    localparam logic [Q_WIDTH-1:0] T18 = vhd_pow2(62 - STAGE * 37) / 37;
    localparam logic [Q_WIDTH-1:0] T19 = vhd_pow2(62 - STAGE * 39) / 39;
    localparam logic [Q_WIDTH-1:0] T20 = vhd_pow2(62 - STAGE * 41) / 41;
    localparam logic [Q_WIDTH-1:0] T21 = vhd_pow2(62 - STAGE * 43) / 43;
    localparam logic [Q_WIDTH-1:0] T22 = vhd_pow2(62 - STAGE * 45) / 45;
    localparam logic [Q_WIDTH-1:0] T23 = vhd_pow2(62 - STAGE * 47) / 47;
    localparam logic [Q_WIDTH-1:0] T24 = vhd_pow2(62 - STAGE * 49) / 49;
    localparam logic [Q_WIDTH-1:0] T25 = vhd_pow2(62 - STAGE * 51) / 51;
    localparam logic [Q_WIDTH-1:0] T26 = vhd_pow2(62 - STAGE * 53) / 53;
    localparam logic [Q_WIDTH-1:0] T27 = vhd_pow2(62 - STAGE * 55) / 55;
    localparam logic [Q_WIDTH-1:0] T28 = vhd_pow2(62 - STAGE * 57) / 57;
    localparam logic [Q_WIDTH-1:0] T29 = vhd_pow2(62 - STAGE * 59) / 59;
    localparam logic [Q_WIDTH-1:0] T30 = vhd_pow2(62 - STAGE * 61) / 61;
    localparam logic [Q_WIDTH-1:0] SERIES =
        T0 - T1 + T2 - T3 + T4 - T5 + T6 - T7 + T8 - T9 + T10 - T11 + T12 - T13
        + T14 - T15 + T16 - T17 + T18 - T19 + T20 - T21 + T22 - T23 + T24 - T25
        + T26 - T27 + T28 - T29 + T30;
    localparam logic [Q_WIDTH-1:0] ANGLE = (STAGE == 0) ? QUARTER_PIQ62 : SERIES;

    logic               valid_reg;
    vhd_beat_t          beat_reg, beat_next;
    logic [Q_WIDTH-1:0] dx, dy;

    // one vectoring rotation, direction from the sign of y
    always_comb
    begin
        dx             = $signed(in_beat.y) >>> STAGE;
        dy             = in_beat.x >> STAGE;
        beat_next.meta = in_beat.meta;
        if (!in_beat.y[Q_WIDTH-1])
        begin
            beat_next.x = in_beat.x + dx;
            beat_next.y = in_beat.y - dy;
            beat_next.z = in_beat.z + ANGLE;
        end
        else
        begin
            beat_next.x = in_beat.x - dx;
            beat_next.y = in_beat.y + dy;
            beat_next.z = in_beat.z - ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

// ----- rtl/vhd_back.sv -----
module vhd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  vhd_pkg::vhd_beat_t in_beat,
    output logic               done,
    output logic [8:0]         heading_deg
);
    import vhd_pkg::*;

    logic                 valid_reg [DIV_STEPS];
    logic [Q_WIDTH-1:0]   rem_reg   [DIV_STEPS];
    logic [DIV_STEPS-1:0] q_reg     [DIV_STEPS];
    vhd_meta_t            meta_reg  [DIV_STEPS];

    logic                 valid_in  [DIV_STEPS];
    logic [Q_WIDTH-1:0]   rem_in    [DIV_STEPS];
    logic [DIV_STEPS-1:0] q_in      [DIV_STEPS];
    vhd_meta_t            meta_in   [DIV_STEPS];

    logic                 done_reg;
    logic [8:0]           heading_reg, heading_next;
    logic [5:0]           oct;
    logic [6:0]           deg;

    // restoring division by one degree, one quotient bit a stage
    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        localparam logic [Q_WIDTH-1:0] DIVISOR = DEG_Q62 << (DIV_STEPS - 1 - j);
        logic                 ge;
        logic [Q_WIDTH-1:0]   rem_next;
        logic [DIV_STEPS-1:0] q_next;

        if (j == 0)
        begin : g_first
            // a negative angle counts as zero
            assign valid_in[j] = in_valid;
            assign rem_in[j]   = in_beat.z[Q_WIDTH-1] ? '0 : in_beat.z;
            assign q_in[j]     = '0;
            assign meta_in[j]  = in_beat.meta;
        end
        else
        begin : g_rest
            assign valid_in[j] = valid_reg[j-1];
            assign rem_in[j]   = rem_reg[j-1];
            assign q_in[j]     = q_reg[j-1];
            assign meta_in[j]  = meta_reg[j-1];
        end

        always_comb
        begin
            ge       = rem_in[j] >= DIVISOR;
            rem_next = ge ? (rem_in[j] - DIVISOR) : rem_in[j];
            q_next   = {q_in[j][DIV_STEPS-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else
            begin
                valid_reg[j] <= valid_in[j];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j]  <= rem_next;
            q_reg[j]    <= q_next;
            meta_reg[j] <= meta_in[j];
        end
    end

    // cap, mirror the steep octant, add the quadrant base; special beats take the base alone
    always_comb
    begin
        oct = (q_reg[DIV_STEPS-1] > OCT_MAX) ? OCT_MAX : q_reg[DIV_STEPS-1];
        deg = meta_reg[DIV_STEPS-1].steep ? (STEEP_TOP - 7'(oct)) : 7'(oct);
        if (meta_reg[DIV_STEPS-1].special)
        begin
            heading_next = meta_reg[DIV_STEPS-1].base;
        end
        else
        begin
            heading_next = meta_reg[DIV_STEPS-1].base + 9'(deg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_reg[DIV_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        heading_reg <= heading_next;
    end

    assign done        = done_reg;
    assign heading_deg = heading_reg;

endmodule

// ----- rtl/vector_heading_degrees_core.sv -----
// throughput: one beat every cycle, busy is never raised
// depth is set by the 62-iteration cordic, one rotation per stage,
// plus four fold/normalize stages, six divide stages and the output register
// reset (rst_n low, asynchronous) clears every valid bit; beats in flight are dropped
// done is a single-cycle strobe and the receiver cannot stall it
module vector_heading_degrees_core #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] x_offset,
    input  logic signed [COORD_WIDTH-1:0] y_offset,
    output logic                          done,
    output logic [8:0]                    heading_deg
);
    import vhd_pkg::*;

    logic      pipe_valid [CORDIC_STEPS+1];
    vhd_beat_t pipe_beat  [CORDIC_STEPS+1];

    // the pipe never backs up
    assign busy = 1'b0;

    // fold into the first octant and normalize
    vhd_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .x_offset  (x_offset),
        .y_offset  (y_offset),
        .out_valid (pipe_valid[0]),
        .out_beat  (pipe_beat[0])
    );

    // cordic rotations
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        vhd_cordic_stage #(
            .STAGE (i)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (pipe_valid[i]),
            .in_beat   (pipe_beat[i]),
            .out_valid (pipe_valid[i+1]),
            .out_beat  (pipe_beat[i+1])
        );
    end

    // angle to whole degrees and final heading
    vhd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (pipe_valid[CORDIC_STEPS]),
        .in_beat     (pipe_beat[CORDIC_STEPS]),
        .done        (done),
        .heading_deg (heading_deg)
    );

endmodule

// ----- rtl/vhd_checker.sv -----
module vhd_checker #(
    parameter int COORD_WIDTH = 16
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic signed [COORD_WIDTH-1:0] x_offset,
    input logic signed [COORD_WIDTH-1:0] y_offset,
    input logic                          done,
    input logic [8:0]                    heading_deg
);
    import vhd_pkg::*;

    // every accepted beat comes out after the fixed latency
    a_start_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##VHD_LATENCY done)
        else $error("accepted beat did not produce a result");

    // no result without a beat accepted the fixed latency before
    a_done_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, VHD_LATENCY))
        else $error("result without a matching accepted beat");

    // heading stays inside one turn
    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (heading_deg < 9'd360))
        else $error("heading out of range");

    // the zero vector reports zero
    a_zero_vector: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && x_offset == '0 && y_offset == '0)
        |-> ##VHD_LATENCY (heading_deg == DEG_0))
        else $error("zero vector gave a nonzero heading");

endmodule

bind vector_heading_degrees_core vhd_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_vhd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .x_offset    (x_offset),
    .y_offset    (y_offset),
    .done        (done),
    .heading_deg (heading_deg)
);
